// ----- design/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg
// shared widths and status codes of the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int KEY_W    = 32;
   localparam int NAME_W   = 48;
   localparam int GRADE_W  = 16;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   typedef logic [STATUS_W-1:0] status_type;

   // result status codes
   localparam status_type ST_ADDED   = 3'd0;
   localparam status_type ST_FULL    = 3'd1;
   localparam status_type ST_DUP     = 3'd2;
   localparam status_type ST_REMOVED = 3'd3;
   localparam status_type ST_MISSING = 3'd4;

   // operation codes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

endpackage

// ----- design/keyed_record_table_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// compact unsorted table of keyed records with add and remove by key
// ----------------------------------------------------------------------------
// Holds up to ENTRIES records (32-bit key, min(NAME_BYTES,6) name bytes, 16-bit
// grade) packed from entry 0 upward with no gaps. An add transaction is
// refused when the table is full or the key is already held, otherwise the
// record goes after the last one. A remove transaction searches for the key
// and closes the gap by moving every later record down one place. Each
// request gives one response with a status and the record count afterwards.
// Rate: the block takes one request at a time and keeps req_stall high until
// that request has reached the response register. The record memory has one
// read port that the search and the compaction walk one entry per cycle. An
// add to a full table is refused without a search; an add with a new key or
// a missing remove walks every held record; a remove that finds its key at
// place p then copies each later record down one place. The memory needs
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module keyed_record_table_unit #(
   parameter int ENTRIES    = 128,
   parameter int NAME_BYTES = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [krt_pkg::KEY_W-1:0]         req_record_key,
   input  logic [krt_pkg::NAME_W-1:0]        req_name_chars,
   input  logic signed [krt_pkg::GRADE_W-1:0] req_grade,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [krt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [krt_pkg::COUNT_W-1:0]       rsp_record_count
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   // kept name bytes, never more than the name port carries
   localparam int STORE_W = (NAME_BYTES * 8 < krt_pkg::NAME_W) ? NAME_BYTES * 8
                                                                : krt_pkg::NAME_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_DONE
   } state_type;

   // sequencer state
   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   krt_pkg::status_type          stat_ff, stat_in;

   // latched request
   logic                         mode_ff, mode_in;
   logic [krt_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [STORE_W-1:0]           name_ff, name_in;
   logic [krt_pkg::GRADE_W-1:0]  grade_ff, grade_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   krt_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [krt_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // record memory
   logic [krt_pkg::KEY_W-1:0]    key_mem   [ENTRIES];
   logic [STORE_W-1:0]           name_mem  [ENTRIES];
   logic [krt_pkg::GRADE_W-1:0]  grade_mem [ENTRIES];
   logic [krt_pkg::KEY_W-1:0]    key_rd_ff;
   logic [STORE_W-1:0]           name_rd_ff;
   logic [krt_pkg::GRADE_W-1:0]  grade_rd_ff;

   logic [IDX_W-1:0]             rd_addr;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [krt_pkg::KEY_W-1:0]    wr_key;
   logic [STORE_W-1:0]           wr_name;
   logic [krt_pkg::GRADE_W-1:0]  wr_grade;

   logic                         pos_held;
   logic                         key_hit;
   logic                         last_held;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_record_count = rsp_count_ff;

   // entry under test is a held record, and is it the last one
   assign pos_held  = (CNT_W'(pos_ff) < fill_ff);
   assign key_hit   = pos_held && (key_rd_ff == key_ff);
   assign last_held = ((CNT_W'(pos_ff) + CNT_W'(1)) >= fill_ff);

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         name_mem[wr_addr]  <= wr_name;
         grade_mem[wr_addr] <= wr_grade;
      end
      key_rd_ff   <= key_mem[rd_addr];
      name_rd_ff  <= name_mem[rd_addr];
      grade_rd_ff <= grade_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      stat_in       = stat_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      name_in       = name_ff;
      grade_in      = grade_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = pos_ff + IDX_W'(1);
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_key        = key_ff;
      wr_name       = name_ff;
      wr_grade      = grade_ff;

      // response taken downstream
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            // start the search at entry 0 in the cycle the request arrives
            rd_addr = '0;
            if (req_valid) begin
               mode_in  = req_mode;
               key_in   = req_record_key;
               name_in  = req_name_chars[STORE_W-1:0];
               grade_in = req_grade;
               pos_in   = '0;
               if (req_mode == krt_pkg::OP_ADD && fill_ff == CNT_W'(ENTRIES)) begin
                  stat_in  = krt_pkg::ST_FULL;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            // read of the next entry already in flight at pos + 1
            if (key_hit) begin
               if (mode_ff == krt_pkg::OP_ADD) begin
                  stat_in  = krt_pkg::ST_DUP;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (last_held) begin
               if (mode_ff == krt_pkg::OP_ADD) begin
                  // append after the last record
                  wr_en    = 1'b1;
                  wr_addr  = fill_ff[IDX_W-1:0];
                  fill_in  = fill_ff + CNT_W'(1);
                  stat_in  = krt_pkg::ST_ADDED;
               end else begin
                  stat_in  = krt_pkg::ST_MISSING;
               end
               state_in = S_DONE;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
         end
         S_SHIFT: begin
            // read data holds entry pos + 1, copy it down to pos
            rd_addr = pos_ff + IDX_W'(2);
            if (!last_held) begin
               wr_en    = 1'b1;
               wr_key   = key_rd_ff;
               wr_name  = name_rd_ff;
               wr_grade = grade_rd_ff;
               pos_in   = pos_ff + IDX_W'(1);
            end else begin
               fill_in  = fill_ff - CNT_W'(1);
               stat_in  = krt_pkg::ST_REMOVED;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_count_in  = krt_pkg::COUNT_W'(fill_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      stat_ff       <= stat_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      name_ff       <= name_in;
      grade_ff      <= grade_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

// ----- design/krt_checker.sv -----
// ----------------------------------------------------------------------------
// krt_checker
// port-level checks of the keyed record table
// ----------------------------------------------------------------------------
module krt_checker #(
   parameter int ENTRIES = 128
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [krt_pkg::STATUS_W-1:0] rsp_status,
   input logic [krt_pkg::COUNT_W-1:0]  rsp_record_count
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_record_count))
      else $error("stalled response changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // only defined status codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == krt_pkg::ST_ADDED || rsp_status == krt_pkg::ST_FULL
         || rsp_status == krt_pkg::ST_DUP || rsp_status == krt_pkg::ST_REMOVED
         || rsp_status == krt_pkg::ST_MISSING))
      else $error("undefined status code");

   // a full refusal reports a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == krt_pkg::ST_FULL
         |-> rsp_record_count == krt_pkg::COUNT_W'(ENTRIES))
      else $error("full status with table not full");

endmodule

bind keyed_record_table_unit krt_checker #(.ENTRIES(ENTRIES)) u_krt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_record_count (rsp_record_count)
);
